/* rtl/core/bstd_pkg.sv */
// Shared types and constants for the bypass shadow tag directory.
// Request/result payload structs, directory entry layout, register indexes.
// No dependencies.
`default_nettype none

package bstd_pkg;

    localparam int ADDR_W      = 58;
    localparam int PC_W        = 48;
    localparam int STAMP_W     = 48;
    localparam int LIMIT_W     = 5;
    localparam int COUNT_OUT_W = 4;
    localparam int SET_IN_W    = 10;
    localparam int CFG_IDX_W   = 1;

    // request kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_PROBE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRAM_WAY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NVM_WAY_LIMIT  = 1'b1;

    localparam logic [LIMIT_W-1:0] SRAM_LIMIT_RESET = 5'd4;
    localparam logic [LIMIT_W-1:0] NVM_LIMIT_RESET  = 5'd12;

    typedef struct packed {
        logic                kind;
        logic [SET_IN_W-1:0] set_index;
        logic [ADDR_W-1:0]   line_addr;
        logic                in_nvm;
        logic [PC_W-1:0]     miss_pc;
    } req_t;

    typedef struct packed {
        logic                   present;
        logic                   stored_site;
        logic [PC_W-1:0]        stored_pc;
        logic [COUNT_OUT_W-1:0] newer_count;
        logic                   within_array;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
        logic               site;
        logic [PC_W-1:0]    pc;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/core/bstd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module bstd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/bstd_row_eval.sv */
// Per-row compare logic: address match, first free way, newer-entry count.
// Depends on bstd_pkg (entry layout).
`default_nettype none

module bstd_row_eval
    import bstd_pkg::*;
#(
    parameter int WAYS = 16
) (
    input  wire entry_t [WAYS-1:0]                          row,
    input  wire logic   [ADDR_W-1:0]                        line_addr,
    input  wire logic                                       in_nvm,
    input  wire logic   [STAMP_W-1:0]                       ref_stamp,
    output logic                                            found,
    output logic        [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] hit_way,
    output logic                                            free_found,
    output logic        [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] free_way,
    output logic        [$clog2(WAYS + 1)-1:0]              newer_count
);

    localparam int WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(WAYS + 1);

    // lowest matching / lowest invalid way wins
    always_comb
    begin
        found      = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w].valid && row[w].addr == line_addr)
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!row[w].valid)
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        newer_count = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row[w].valid && row[w].site == in_nvm && row[w].stamp > ref_stamp)
            begin
                newer_count = newer_count + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bypass_shadow_tag_directory.sv */
// Set-associative shadow tag directory, one row (all ways of a set) per RAM word.
// Flow: S_LOOK registers the match, S_COUNT registers the result strobe; probes, record
// hits and record fills of a free way finish there. A record miss on a full set then
// scans stamps one way a cycle for LRU in S_SCAN and writes the victim in S_WRITE.
// Reset: busy stays high for a clearing pass over all SETS rows, one row per cycle.
// Results are shown for one cycle only; the receiver cannot stall.
`default_nettype none

module bypass_shadow_tag_directory
    import bstd_pkg::*;
#(
    parameter int SETS = 1024,
    parameter int WAYS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire req_t                 request,
    output logic                      busy,
    output logic                      result_valid,
    output rsp_t                      result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_data
);

    localparam int SET_W   = SETS > 1 ? $clog2(SETS) : 1;
    localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int CNT_W   = $clog2(WAYS + 1);
    localparam int CE_W    = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;
    localparam int ROW_W   = WAYS * $bits(entry_t);
    localparam bit SET_P2  = (SETS & (SETS - 1)) == 0;
    localparam int SET_MAX = (1 << SET_IN_W) - 1;

    function automatic int mod_steps(input int s);
        int n;
        n = 0;
        while ((s << n) <= SET_MAX)
        begin
            n = n + 1;
        end
        return n;
    endfunction

    localparam int MOD_STEPS = mod_steps(SETS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_COUNT = 6'b001000,
        S_SCAN  = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [SET_W-1:0]    clr_reg, clr_next;
    req_t                req_reg, req_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic                found_reg, found_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic                free_found_reg, free_found_next;
    logic [WAY_W-1:0]    free_way_reg, free_way_next;
    logic [STAMP_W-1:0]  ref_stamp_reg, ref_stamp_next;
    logic                hit_site_reg, hit_site_next;
    logic [PC_W-1:0]     hit_pc_reg, hit_pc_next;
    logic [WAY_W-1:0]    victim_reg, victim_next;
    logic [STAMP_W-1:0]  oldest_reg, oldest_next;
    logic [WAY_W-1:0]    scan_reg, scan_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [LIMIT_W-1:0]  sram_lim_reg, sram_lim_next;
    logic [LIMIT_W-1:0]  nvm_lim_reg, nvm_lim_next;
    rsp_t                result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic                accept;
    logic [SET_W-1:0]    set_mod;
    logic [SET_IN_W-1:0] mod_r;

    logic                ram_we;
    logic [SET_W-1:0]    ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ROW_W-1:0]    ram_rdata;
    entry_t [WAYS-1:0]   row;
    entry_t [WAYS-1:0]   wrow;
    logic [WAY_W-1:0]    fill_way;

    logic                ev_found;
    logic [WAY_W-1:0]    ev_hit_way;
    logic                ev_free_found;
    logic [WAY_W-1:0]    ev_free_way;
    logic [CNT_W-1:0]    ev_count;
    logic [CE_W-1:0]     cnt_ext;
    logic [LIMIT_W-1:0]  limit_sel;

    assign busy   = state_reg != S_IDLE;
    assign accept = start && !busy;

    // set index reduced modulo SETS: mask for powers of two, else binary long division
    always_comb
    begin
        mod_r = request.set_index;
        if (!SET_P2)
        begin
            for (int k = MOD_STEPS - 1; k >= 0; k--)
            begin
                if (int'(mod_r) >= (SETS << k))
                begin
                    mod_r = mod_r - SET_IN_W'(SETS << k);
                end
            end
        end
    end

    assign set_mod = SET_W'(mod_r);

    bstd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_mod),
        .rdata (ram_rdata)
    );

    assign row = ram_rdata;

    bstd_row_eval #(
        .WAYS (WAYS)
    ) u_eval (
        .row         (row),
        .line_addr   (req_reg.line_addr),
        .in_nvm      (req_reg.in_nvm),
        .ref_stamp   (ref_stamp_reg),
        .found       (ev_found),
        .hit_way     (ev_hit_way),
        .free_found  (ev_free_found),
        .free_way    (ev_free_way),
        .newer_count (ev_count)
    );

    // write-back row: refresh stamp on hit, else install new entry
    assign fill_way = (state_reg == S_COUNT) ? free_way_reg : victim_reg;

    always_comb
    begin
        wrow = row;
        if (found_reg)
        begin
            wrow[hit_way_reg].stamp = stamp_reg;
        end
        else
        begin
            wrow[fill_way].valid = 1'b1;
            wrow[fill_way].addr  = req_reg.line_addr;
            wrow[fill_way].stamp = stamp_reg;
            wrow[fill_way].site  = req_reg.in_nvm;
            wrow[fill_way].pc    = req_reg.miss_pc;
        end
    end

    assign cnt_ext   = found_reg ? CE_W'(ev_count) : '0;
    assign limit_sel = req_reg.in_nvm ? nvm_lim_reg : sram_lim_reg;

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        req_next          = req_reg;
        set_next          = set_reg;
        found_next        = found_reg;
        hit_way_next      = hit_way_reg;
        free_found_next   = free_found_reg;
        free_way_next     = free_way_reg;
        ref_stamp_next    = ref_stamp_reg;
        hit_site_next     = hit_site_reg;
        hit_pc_next       = hit_pc_reg;
        victim_next       = victim_reg;
        oldest_next       = oldest_reg;
        scan_next         = scan_reg;
        stamp_next        = stamp_reg;
        sram_lim_next     = sram_lim_reg;
        nvm_lim_next      = nvm_lim_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = set_reg;
        ram_wdata         = wrow;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRAM_WAY_LIMIT: sram_lim_next = cfg_data;
                REG_NVM_WAY_LIMIT:  nvm_lim_next  = cfg_data;
                default:            ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + SET_W'(1);
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    set_next   = set_mod;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                found_next      = ev_found;
                hit_way_next    = ev_hit_way;
                free_found_next = ev_free_found;
                free_way_next   = ev_free_way;
                ref_stamp_next  = row[ev_hit_way].stamp;
                hit_site_next   = row[ev_hit_way].site;
                hit_pc_next     = row[ev_hit_way].pc;
                state_next      = S_COUNT;
            end
            S_COUNT:
            begin
                result_valid_next        = 1'b1;
                result_next.present      = found_reg;
                result_next.stored_site  = found_reg && hit_site_reg;
                result_next.stored_pc    = found_reg ? hit_pc_reg : '0;
                result_next.newer_count  = (cnt_ext > CE_W'(15)) ? COUNT_OUT_W'(15)
                                                                 : cnt_ext[COUNT_OUT_W-1:0];
                result_next.within_array = (req_reg.kind == KIND_PROBE) && found_reg &&
                                           (cnt_ext < CE_W'(limit_sel));
                if (req_reg.kind == KIND_PROBE)
                begin
                    state_next = S_IDLE;
                end
                else if (found_reg || free_found_reg)
                begin
                    ram_we     = 1'b1;
                    stamp_next = stamp_reg + STAMP_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    // full set: LRU scan, strict compare keeps the lowest way on ties
                    victim_next = '0;
                    oldest_next = row[0].stamp;
                    scan_next   = WAY_W'(1);
                    state_next  = (WAYS > 1) ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN:
            begin
                if (row[scan_reg].stamp < oldest_reg)
                begin
                    oldest_next = row[scan_reg].stamp;
                    victim_next = scan_reg;
                end
                scan_next = scan_reg + WAY_W'(1);
                if (scan_reg == WAY_W'(WAYS - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                stamp_next = stamp_reg + STAMP_W'(1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            stamp_reg        <= '0;
            sram_lim_reg     <= SRAM_LIMIT_RESET;
            nvm_lim_reg      <= NVM_LIMIT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            stamp_reg        <= stamp_next;
            sram_lim_reg     <= sram_lim_next;
            nvm_lim_reg      <= nvm_lim_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        set_reg        <= set_next;
        found_reg      <= found_next;
        hit_way_reg    <= hit_way_next;
        free_found_reg <= free_found_next;
        free_way_reg   <= free_way_next;
        ref_stamp_reg  <= ref_stamp_next;
        hit_site_reg   <= hit_site_next;
        hit_pc_reg     <= hit_pc_next;
        victim_reg     <= victim_next;
        oldest_reg     <= oldest_next;
        scan_reg       <= scan_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
